// ----- rtl/ckc_pkg.sv -----
// Shared types and constants for the column k-th smallest cutoff block.
package ckc_pkg;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 4;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 32;

	localparam logic [VALUE_W-1:0] ALL_ONES = '1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;
		logic close;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic diag;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/column_kth_smallest_cutoff.sv -----
// Column k-th smallest cutoff: top level joining controller and datapath.
//
// Elements stream in column by column; off-diagonal ones are inserted into a
// sorted list of MAX_COUNT compare-and-shift cells. After an element without a
// column or matrix end mark the block stays ready for the next one. An element
// closing a column is inserted, then in the close state the datapath reads entry
// count_below-1, raises the running cutoff and refills the list with all-ones.
// An element with the matrix end mark then passes through the emit state, which
// loads the cutoff into the output register and waits there if the previous
// result beat is still untaken. A column with fewer than count_below off-diagonal
// elements gives the all-ones cutoff. count_below resets to 2; 0 acts as 1 and
// values above MAX_COUNT act as MAX_COUNT. Write it only while the block is idle.
module column_kth_smallest_cutoff #(
	parameter int MAX_COUNT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ckc_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// element_value [31:0], row_index [41:32], col_index [51:42], zero [55:52]
	input  logic [ckc_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tlast,   // column_end
	// matrix_end [0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cutoff_value [31:0]
	output logic [ckc_pkg::M_DATA_W-1:0]  m_tdata
);

	ckc_pkg::cmd_t    cmd;
	ckc_pkg::status_t status;

	ckc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_column_end (s_tlast),
		.in_matrix_end (s_tuser),
		.in_ready      (s_tready),
		.status        (status),
		.cmd           (cmd)
	);

	ckc_datapath #(
		.MAX_COUNT (MAX_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.element_value (s_tdata[31:0]),
		.row_index     (s_tdata[41:32]),
		.col_index     (s_tdata[51:42]),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.cutoff_value  (m_tdata)
	);

endmodule

// ----- rtl/ckc_ctrl.sv -----
// Controller: sequences accept, column close and cutoff emit.
module ckc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_column_end,
	input  logic            in_matrix_end,
	output logic            in_ready,
	input  ckc_pkg::status_t status,
	output ckc_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_CLOSE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   mat_end_q;
	logic   accept;

	assign in_ready = (state_q == ST_ACCEPT);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		cmd.insert = accept && !status.diag;
		cmd.close  = (state_q == ST_CLOSE);
		cmd.emit   = (state_q == ST_EMIT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ACCEPT;
			mat_end_q <= 1'b0;
		end else begin
			case (state_q)
				ST_ACCEPT: begin
					if (accept && (in_column_end || in_matrix_end)) begin
						state_q   <= ST_CLOSE;
						mat_end_q <= in_matrix_end;
					end
				end
				ST_CLOSE: begin
					state_q <= mat_end_q ? ST_EMIT : ST_ACCEPT;
				end
				ST_EMIT: begin
					// hold until the output register can take the beat
					if (status.out_free) begin
						state_q <= ST_ACCEPT;
					end
				end
				default: begin
					state_q <= ST_ACCEPT;
				end
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACCEPT) |-> !cmd.insert)
		else $error("insert issued while closing or emitting");

	a_close_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.close && mat_end_q) |=> (state_q == ST_EMIT))
		else $error("matrix end close did not lead to emit");

	a_close_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> !cmd.close)
		else $error("column close lasted more than one cycle");

endmodule

// ----- rtl/ckc_datapath.sv -----
// Datapath: sorted insert cells, count register, running cutoff and output register.
module ckc_datapath #(
	parameter int MAX_COUNT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ckc_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic [ckc_pkg::VALUE_W-1:0]   element_value,
	input  logic [ckc_pkg::INDEX_W-1:0]   row_index,
	input  logic [ckc_pkg::INDEX_W-1:0]   col_index,
	input  ckc_pkg::cmd_t                 cmd,
	output ckc_pkg::status_t              status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [ckc_pkg::VALUE_W-1:0]   cutoff_value
);

	localparam int SEL_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

	logic [ckc_pkg::VALUE_W-1:0] list_q [MAX_COUNT];
	logic [ckc_pkg::VALUE_W-1:0] list_nxt [MAX_COUNT];
	logic [MAX_COUNT-1:0]        below;
	logic [ckc_pkg::COUNT_W-1:0] count_q;
	logic [ckc_pkg::COUNT_W-1:0] k_lim;
	logic [SEL_W-1:0]            sel;
	logic [ckc_pkg::VALUE_W-1:0] kth;
	logic [ckc_pkg::VALUE_W-1:0] cutoff_q;
	logic [ckc_pkg::VALUE_W-1:0] out_q;
	logic                        out_valid_q;

	assign status.diag     = (row_index == col_index);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign cutoff_value    = out_q;

	// Each cell keeps its entry, takes the new value, or takes its lower neighbor.
	always_comb begin
		for (int i = 0; i < MAX_COUNT; i++) begin
			below[i] = (list_q[i] < element_value);
		end
		for (int i = 0; i < MAX_COUNT; i++) begin
			if (below[i]) begin
				list_nxt[i] = list_q[i];
			end else if (i == 0) begin
				list_nxt[i] = element_value;
			end else if (below[i-1]) begin
				list_nxt[i] = element_value;
			end else begin
				list_nxt[i] = list_q[i-1];
			end
		end
	end

	always_comb begin
		k_lim = (count_q == '0) ? ckc_pkg::COUNT_W'(1) : count_q;
		if (32'(k_lim) > MAX_COUNT) begin
			k_lim = ckc_pkg::COUNT_W'(MAX_COUNT);
		end
		sel = SEL_W'(k_lim - ckc_pkg::COUNT_W'(1));
		kth = list_q[sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ckc_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_COUNT; i++) begin
				list_q[i] <= ckc_pkg::ALL_ONES;
			end
		end else if (cmd.close) begin
			for (int i = 0; i < MAX_COUNT; i++) begin
				list_q[i] <= ckc_pkg::ALL_ONES;
			end
		end else if (cmd.insert) begin
			for (int i = 0; i < MAX_COUNT; i++) begin
				list_q[i] <= list_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.close && (cutoff_q < kth)) begin
				cutoff_q <= kth;
			end else if (cmd.emit) begin
				cutoff_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= cutoff_q;
		end
	end

	a_emit_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("emit would overwrite an untaken beat");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (cutoff_q == '0) && out_valid_q)
		else $error("emit did not clear cutoff or raise valid");

	a_close_resets_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> (list_q[0] == ckc_pkg::ALL_ONES))
		else $error("list not cleared after column close");

endmodule

// ----- tb/sv/tb_column_kth_smallest_cutoff.sv -----
// Self-checking testbench for the column k-th smallest cutoff block.
`timescale 1ns / 1ps

module tb_column_kth_smallest_cutoff;

	localparam int KEPT = 8;
	localparam int PHASE_ITEMS = 175;
	localparam int DRAIN_CYCLES = 8;
	localparam int STUCK_LIMIT = 2000;

	typedef struct packed {
		logic [ckc_pkg::VALUE_W-1:0] distance;
		logic [ckc_pkg::INDEX_W-1:0] row;
		logic [ckc_pkg::INDEX_W-1:0] col;
		logic                        col_end;
		logic                        mat_end;
	} element_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [ckc_pkg::COUNT_W-1:0]  cfg_wdata = '0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [ckc_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic                         s_tlast = 1'b0;
	logic                         s_tuser = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [ckc_pkg::M_DATA_W-1:0] m_tdata;

	// Stimulus and prediction state
	element_t                    element_queue[$];
	element_t                    in_flight;
	logic [ckc_pkg::VALUE_W-1:0] cutoff_expect[$];
	logic [ckc_pkg::VALUE_W-1:0] kept_values[KEPT];
	logic [ckc_pkg::VALUE_W-1:0] running_cutoff;
	logic [ckc_pkg::COUNT_W-1:0] model_count;
	logic [ckc_pkg::VALUE_W-1:0] last_distance = '0;
	logic [ckc_pkg::VALUE_W-1:0] want_cutoff;
	int                          queued_items = 0;
	int                          mismatches = 0;
	int                          tx_wait = 0;
	int                          rx_wait = 0;
	int                          stuck_cycles = 0;
	bit                          tx_steady = 1'b0;
	bit                          rx_steady = 1'b0;

	column_kth_smallest_cutoff i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void clear_kept();
		for (int i = 0; i < KEPT; i++) begin
			kept_values[i] = ckc_pkg::ALL_ONES;
		end
	endfunction

	// Advance the cutoff model by one accepted element.
	function automatic void predict_cutoff(element_t e);
		int pos;
		int k;
		logic [ckc_pkg::VALUE_W-1:0] kth;
		if (e.row != e.col) begin
			pos = 0;
			while (pos < KEPT && kept_values[pos] < e.distance) pos++;
			if (pos < KEPT) begin
				for (int i = KEPT - 1; i > pos; i--) begin
					kept_values[i] = kept_values[i-1];
				end
				kept_values[pos] = e.distance;
			end
		end
		if (e.col_end || e.mat_end) begin
			k = (model_count == 0) ? 1 : (model_count > KEPT) ? KEPT : int'(model_count);
			kth = kept_values[k-1];
			if (running_cutoff < kth) running_cutoff = kth;
			clear_kept();
		end
		if (e.mat_end) begin
			cutoff_expect.push_back(running_cutoff);
			running_cutoff = '0;
		end
	endfunction

	function automatic logic [ckc_pkg::VALUE_W-1:0] draw_distance();
		logic [ckc_pkg::VALUE_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 15);
			1: v = ckc_pkg::ALL_ONES;
			2: v = ckc_pkg::ALL_ONES - $urandom_range(0, 15);
			3: v = 32'd1 << $urandom_range(0, 31);
			4: v = last_distance;
			default: v = $urandom();
		endcase
		last_distance = v;
		return v;
	endfunction

	task automatic push_element(logic [31:0] d, logic [9:0] r, logic [9:0] c, bit ce, bit me);
		element_t e;
		e.distance = d;
		e.row = r;
		e.col = c;
		e.col_end = ce;
		e.mat_end = me;
		element_queue.push_back(e);
		queued_items++;
	endtask

	// Push one matrix column by column; optionally close it with matrix end alone.
	task automatic push_matrix(int n_cols, int max_rows, bit drop_col_end);
		logic [9:0] base;
		logic [9:0] col;
		logic [9:0] row;
		int n_rows;
		bit last_col;
		bit last_row;
		base = 10'($urandom_range(0, 1023));
		for (int c = 0; c < n_cols; c++) begin
			col = base + 10'(c);
			n_rows = $urandom_range(1, max_rows);
			last_col = (c == n_cols - 1);
			for (int r = 0; r < n_rows; r++) begin
				last_row = (r == n_rows - 1);
				row = ($urandom_range(0, 5) == 0) ? col : 10'($urandom_range(0, 1023));
				push_element(draw_distance(), row, col,
					last_row && !(last_col && drop_col_end), last_row && last_col);
			end
		end
	endtask

	task automatic push_noise(int n);
		logic [9:0] col;
		for (int i = 0; i < n; i++) begin
			col = 10'($urandom_range(0, 1023));
			push_element(draw_distance(),
				($urandom_range(0, 3) == 0) ? col : 10'($urandom_range(0, 1023)), col,
				$urandom_range(0, 3) == 0, $urandom_range(0, 11) == 0);
		end
	endtask

	// Hold until the block has taken everything and returned every cutoff.
	task automatic wait_drained();
		do @(negedge clk);
		while (element_queue.size() != 0 || s_tvalid || cutoff_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(logic [ckc_pkg::COUNT_W-1:0] k);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_count = k;
	endtask

	// Driver: one beat per element, random gap after each accepted beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_cutoff(in_flight);
				tx_wait = tx_steady ? 0 : $urandom_range(0, 4);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					tx_wait = tx_wait - 1;
					s_tvalid <= 1'b0;
				end else if (element_queue.size() != 0) begin
					in_flight = element_queue.pop_front();
					s_tdata <= {4'b0, in_flight.col, in_flight.row, in_flight.distance};
					s_tlast <= in_flight.col_end;
					s_tuser <= in_flight.mat_end;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each cutoff beat with the oldest prediction.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (cutoff_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected cutoff_value %h", m_tdata);
			end else begin
				want_cutoff = cutoff_expect.pop_front();
				if (m_tdata !== want_cutoff) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cutoff_value: expected %h, got %h", want_cutoff, m_tdata);
				end
			end
			rx_wait = rx_steady ? 0 : $urandom_range(0, 4);
		end else if (rx_wait > 0) begin
			rx_wait = rx_wait - 1;
		end
		m_tready <= (rx_wait == 0);
	end

	// Watchdog: count cycles with work outstanding but no beat moving.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(element_queue.size() == 0 && !s_tvalid && cutoff_expect.size() == 0))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [ckc_pkg::COUNT_W-1:0] phase_counts[8];
		int phase_start;
		clear_kept();
		running_cutoff = '0;
		model_count = ckc_pkg::COUNT_RESET;
		phase_counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd0, 4'd0, 4'd0, 4'd0};
		for (int p = 4; p < 8; p++) phase_counts[p] = 4'($urandom_range(0, 15));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: lone diagonal closing a matrix gives all-ones
		push_element(32'h0, 10'd0, 10'd0, 1'b1, 1'b1);
		// extremes of value and index, diagonal with marks
		push_element(32'h0, 10'd0, 10'd1023, 1'b0, 1'b0);
		push_element(ckc_pkg::ALL_ONES, 10'd1022, 10'd1023, 1'b0, 1'b0);
		push_element(32'h5, 10'd1023, 10'd1023, 1'b1, 1'b0);
		// ties within a column
		push_element(32'h9, 10'd3, 10'd0, 1'b0, 1'b0);
		push_element(32'h9, 10'd4, 10'd0, 1'b0, 1'b0);
		push_element(32'h9, 10'd5, 10'd0, 1'b0, 1'b0);
		push_element(32'h9, 10'd0, 10'd0, 1'b1, 1'b0);
		// matrix end without column end
		push_element(32'h7, 10'd0, 10'd512, 1'b0, 1'b0);
		push_element(32'h3, 10'd1, 10'd512, 1'b0, 1'b1);
		// short column among full ones, count at reset
		push_element(32'hAAAA_5555, 10'd2, 10'd1, 1'b0, 1'b0);
		push_element(32'h5555_AAAA, 10'd0, 10'd1, 1'b1, 1'b0);
		push_element(32'h1234_5678, 10'd2, 10'd2, 1'b1, 1'b0);
		push_element(32'h8000_0000, 10'd0, 10'd3, 1'b0, 1'b0);
		push_element(32'h7FFF_FFFF, 10'd1, 10'd3, 1'b1, 1'b1);
		// more than eight elements in a column
		for (int i = 0; i < 9; i++)
			push_element(32'(20 - i), 10'(i + 1), 10'd0, i == 8, i == 8);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			write_count(phase_counts[p]);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			phase_start = queued_items;
			while (queued_items - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 5) == 0)
					push_noise($urandom_range(1, 6));
				else
					push_matrix($urandom_range(1, 4), 10, $urandom_range(0, 3) == 0);
				if (p == 2 && queued_items - phase_start > PHASE_ITEMS / 2 &&
						queued_items - phase_start <= PHASE_ITEMS / 2 + 40) begin
					// pause until every pending cutoff has come back
					wait_drained();
					phase_start = phase_start - 40;
				end
			end
			if (p == 5) begin
				// change the count partway through a column
				push_element(draw_distance(), 10'd1, 10'd7, 1'b1, 1'b1);
				push_element(draw_distance(), 10'd1, 10'd9, 1'b0, 1'b0);
				push_element(draw_distance(), 10'd2, 10'd9, 1'b0, 1'b0);
				push_element(draw_distance(), 10'd3, 10'd9, 1'b0, 1'b0);
				wait_drained();
				write_count(4'd3);
				push_element(draw_distance(), 10'd4, 10'd9, 1'b1, 1'b1);
			end
			wait_drained();
		end

		repeat (2 * DRAIN_CYCLES) @(negedge clk);
		if (cutoff_expect.size() != 0) mismatches++;
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
